[src/miabu_pkg.sv]
`timescale 1ns / 1ps

package miabu_pkg;

    localparam int XLEN      = 64;
    localparam int REG_COUNT = 32;
    localparam int IDX_W     = $clog2(REG_COUNT);
    localparam int IN_W      = 192;
    localparam int OUT_W     = 144;

    localparam logic [IDX_W-1:0] LINK_REG = IDX_W'(31);

    typedef enum logic [4:0] {
        CMD_LUI    = 5'd0,
        CMD_ADDIU  = 5'd1,
        CMD_SLTI   = 5'd2,
        CMD_SLTIU  = 5'd3,
        CMD_ADDI   = 5'd4,
        CMD_DADDI  = 5'd5,
        CMD_DADDIU = 5'd6,
        CMD_ORI    = 5'd7,
        CMD_ANDI   = 5'd8,
        CMD_XORI   = 5'd9,
        CMD_J      = 5'd10,
        CMD_JAL    = 5'd11,
        CMD_BEQ    = 5'd12,
        CMD_BNE    = 5'd13,
        CMD_BLEZ   = 5'd14,
        CMD_BGTZ   = 5'd15,
        CMD_BEQL   = 5'd16,
        CMD_BNEL   = 5'd17,
        CMD_BLEZL  = 5'd18,
        CMD_BGTZL  = 5'd19
    } command_t;

    typedef struct packed {
        logic [XLEN-1:0]  link_value;
        logic [XLEN-1:0]  current_pc;
        logic [25:0]      jump_field;
        logic [15:0]      imm16;
        logic [IDX_W-1:0] tgt_index;
        logic [IDX_W-1:0] src_index;
        command_t         command;
    } instr_t;

    typedef struct packed {
        logic             overflow;
        logic             skip_delay_slot;
        logic [XLEN-1:0]  branch_target;
        logic             branch_taken;
        logic [XLEN-1:0]  write_value;
        logic [IDX_W-1:0] write_index;
        logic             write_enable;
    } result_t;

endpackage

[src/mips_immediate_alu_branch_unit_top.sv]
`timescale 1ns / 1ps

// Immediate-format ALU and jump/branch execute unit over a 32 x 64-bit register
// file. Items are accepted one per cycle unless stage 1 and the output register
// are both full and the output is not taken. An accepted item is registered in
// stage 1, and its result is loaded into the output register when stage 1
// commits. The register file is a memory with two registered read ports (rs, rt)
// and one write port. The write of an item lands at the edge where the next item
// reads, and a one-entry forwarding register covers that overlap, so dependent
// instructions issue back to back. Reset clears the register file at once through
// per-entry valid bits, so no clearing pass is needed. Register zero always reads zero.
module mips_immediate_alu_branch_unit_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // command, src_index, tgt_index, imm16, jump_field, current_pc, link_value
    input  logic [miabu_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // write_enable, write_index, write_value, branch_taken, branch_target,
    // skip_delay_slot, overflow
    output logic [miabu_pkg::OUT_W-1:0] m_axis_tdata
);
    import miabu_pkg::*;

    localparam int INSTR_W = $bits(instr_t);
    localparam int RES_W   = $bits(result_t);

    instr_t           in_item;
    logic             in_accept;
    logic             s1_adv;
    logic             commit;

    logic [XLEN-1:0]  rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;

    logic             s1_valid_reg;
    instr_t           s1_reg;
    logic [XLEN-1:0]  rd_a_reg;
    logic [XLEN-1:0]  rd_b_reg;
    logic             a_valid_reg;
    logic             b_valid_reg;
    logic             fwd_a_reg;
    logic             fwd_b_reg;
    logic [XLEN-1:0]  fwd_data_reg;

    logic             out_valid_reg;
    result_t          res_reg;
    result_t          res_next;

    logic [XLEN-1:0]  op_a;
    logic [XLEN-1:0]  op_b;
    logic [XLEN-1:0]  simm;
    logic [XLEN-1:0]  sum64;
    logic [31:0]      sum32;
    logic [XLEN-1:0]  br_target;
    logic [XLEN-1:0]  jmp_target;
    logic             cond;
    logic             wr;
    logic [IDX_W-1:0] widx;
    logic [XLEN-1:0]  wval;
    logic             taken;
    logic             skip;
    logic             ovf;

    assign in_item       = s_axis_tdata[INSTR_W-1:0];
    assign s1_adv        = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign commit        = s1_valid_reg && s1_adv;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W - RES_W){1'b0}}, res_reg};

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rd_a_reg <= rf_mem[in_item.src_index];
            rd_b_reg <= rf_mem[in_item.tgt_index];
        end
        if (commit && res_next.write_enable)
        begin
            rf_mem[res_next.write_index] <= res_next.write_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (commit && res_next.write_enable)
        begin
            valid_reg[res_next.write_index] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg       <= in_item;
            a_valid_reg  <= valid_reg[in_item.src_index];
            b_valid_reg  <= valid_reg[in_item.tgt_index];
            fwd_a_reg    <= commit && res_next.write_enable
                            && (res_next.write_index == in_item.src_index);
            fwd_b_reg    <= commit && res_next.write_enable
                            && (res_next.write_index == in_item.tgt_index);
            fwd_data_reg <= res_next.write_value;
        end
        if (commit)
        begin
            res_reg <= res_next;
        end
    end

    // Resolve operands: forwarded write, then stored entry, else reset value
    always_comb
    begin
        if (fwd_a_reg)
        begin
            op_a = fwd_data_reg;
        end
        else if (a_valid_reg)
        begin
            op_a = rd_a_reg;
        end
        else
        begin
            op_a = '0;
        end
        if (fwd_b_reg)
        begin
            op_b = fwd_data_reg;
        end
        else if (b_valid_reg)
        begin
            op_b = rd_b_reg;
        end
        else
        begin
            op_b = '0;
        end
    end

    assign simm       = {{(XLEN-16){s1_reg.imm16[15]}}, s1_reg.imm16};
    assign sum64      = op_a + simm;
    assign sum32      = op_a[31:0] + simm[31:0];
    assign br_target  = s1_reg.current_pc + {simm[XLEN-3:0], 2'b00};
    assign jmp_target = {s1_reg.current_pc[XLEN-1:28], s1_reg.jump_field, 2'b00};

    always_comb
    begin
        wr    = 1'b0;
        widx  = s1_reg.tgt_index;
        wval  = '0;
        taken = 1'b0;
        skip  = 1'b0;
        ovf   = 1'b0;
        cond  = 1'b0;
        case (s1_reg.command)
            CMD_LUI:
            begin
                wr   = 1'b1;
                wval = {{(XLEN-32){s1_reg.imm16[15]}}, s1_reg.imm16, 16'h0000};
            end
            CMD_ADDIU:
            begin
                wr   = 1'b1;
                wval = {{(XLEN-32){sum32[31]}}, sum32};
            end
            CMD_SLTI:
            begin
                wr   = 1'b1;
                wval = {{(XLEN-1){1'b0}}, ($signed(op_a) < $signed(simm))};
            end
            CMD_SLTIU:
            begin
                wr   = 1'b1;
                wval = {{(XLEN-1){1'b0}}, (op_a < simm)};
            end
            CMD_ADDI:
            begin
                ovf = (op_a[31] == simm[31]) && (sum32[31] != op_a[31]);
                wr   = !ovf;
                wval = {{(XLEN-32){sum32[31]}}, sum32};
            end
            CMD_DADDI:
            begin
                ovf = (op_a[XLEN-1] == simm[XLEN-1]) && (sum64[XLEN-1] != op_a[XLEN-1]);
                wr   = !ovf;
                wval = sum64;
            end
            CMD_DADDIU:
            begin
                wr   = 1'b1;
                wval = sum64;
            end
            CMD_ORI:
            begin
                wr   = 1'b1;
                wval = op_a | {{(XLEN-16){1'b0}}, s1_reg.imm16};
            end
            CMD_ANDI:
            begin
                wr   = 1'b1;
                wval = op_a & {{(XLEN-16){1'b0}}, s1_reg.imm16};
            end
            CMD_XORI:
            begin
                wr   = 1'b1;
                wval = op_a ^ {{(XLEN-16){1'b0}}, s1_reg.imm16};
            end
            CMD_J:
            begin
                taken = 1'b1;
            end
            CMD_JAL:
            begin
                taken = 1'b1;
                wr    = 1'b1;
                widx  = LINK_REG;
                wval  = s1_reg.link_value;
            end
            CMD_BEQ, CMD_BEQL:
            begin
                cond = (op_a == op_b);
            end
            CMD_BNE, CMD_BNEL:
            begin
                cond = (op_a != op_b);
            end
            CMD_BLEZ, CMD_BLEZL:
            begin
                cond = op_a[XLEN-1] || (op_a == '0);
            end
            CMD_BGTZ, CMD_BGTZL:
            begin
                cond = !op_a[XLEN-1] && (op_a != '0);
            end
            default:
            begin
                wr = 1'b0;
            end
        endcase

        if (s1_reg.command inside {[CMD_BEQ:CMD_BGTZL]})
        begin
            taken = cond;
            skip  = !cond && (s1_reg.command inside {[CMD_BEQL:CMD_BGTZL]});
        end

        // Drop writes to register zero
        if (widx == '0)
        begin
            wr = 1'b0;
        end

        res_next.write_enable    = wr;
        res_next.write_index     = wr ? widx : '0;
        res_next.write_value     = wr ? wval : '0;
        res_next.branch_taken    = taken;
        res_next.branch_target   = !taken ? '0 :
                                   (s1_reg.command inside {CMD_J, CMD_JAL}) ? jmp_target
                                                                           : br_target;
        res_next.skip_delay_slot = skip;
        res_next.overflow        = ovf;
    end

`ifndef SYNTHESIS
    a_zero_never_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[0])
        else $error("register zero marked written");

    a_commit_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("committed item missing from output register");

    a_ovf_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.overflow |-> !res_reg.write_enable)
        else $error("write after overflow");

    a_skip_not_taken: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.skip_delay_slot |-> !res_reg.branch_taken)
        else $error("skip on taken branch");

    a_fwd_needs_commit: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !commit |=> !fwd_a_reg && !fwd_b_reg)
        else $error("forwarding without a write");
`endif

endmodule
